[rtl/core/mmcc_pkg.sv]
// package for the magnetometer min/max calibration and correction block
// holds widths, reset constants and register indexes; no dependencies
package mmcc_pkg;
    localparam int SampleBits = 16;
    localparam int GainBits   = 16;
    localparam int FracBits   = 12;
    localparam int CountBits  = 16;
    localparam int LimitBits  = 15;
    localparam int IdxBits    = 2;
    localparam int ProdBits   = SampleBits + 1 + GainBits;
    localparam int CycBits    = 5;

    localparam logic [IdxBits-1:0] RegApply = 2'd0;
    localparam logic [IdxBits-1:0] RegCount = 2'd1;
    localparam logic [IdxBits-1:0] RegLimit = 2'd2;

    localparam logic signed [SampleBits-1:0] MaxInit = -16'sd100;
    localparam logic signed [SampleBits-1:0] MinInit = 16'sd100;
    localparam logic signed [SampleBits-1:0] Off0 = 16'sd232;
    localparam logic signed [SampleBits-1:0] Off1 = -16'sd221;
    localparam logic signed [SampleBits-1:0] Off2 = -16'sd119;
    localparam logic [GainBits-1:0] Gain0 = 16'd4792;
    localparam logic [GainBits-1:0] Gain1 = 16'd5485;
    localparam logic [GainBits-1:0] Gain2 = 16'd4096;
    localparam logic [GainBits-1:0] GainSat = 16'hFFFF;

    typedef struct packed {
        logic                  start;
        logic [SampleBits:0]   top;
        logic [SampleBits:0]   span;
    } div_req_t;
endpackage

[rtl/core/mmcc_mul.sv]
// bit-serial signed by unsigned multiplier, one gain bit per cycle
// depends on mmcc_pkg
module mmcc_mul
    import mmcc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [SampleBits:0]   diff,
    input  logic [GainBits-1:0]          gain,
    output logic                         done,
    output logic signed [SampleBits-1:0] result
);
    logic signed [ProdBits-1:0] acc_reg, acc_next;
    logic [GainBits-1:0] g_reg, g_next;
    logic signed [ProdBits-1:0] d_reg, d_next;
    logic [CycBits-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic signed [ProdBits-1:0] shf;
    logic signed [ProdBits-1:0] smax, smin;

    always_comb begin
        acc_next = acc_reg;
        g_next = g_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && !start && (cnt_reg == CycBits'(GainBits - 1));
        if (start) begin
            acc_next = '0;
            g_next = gain;
            d_next = ProdBits'(diff);
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (g_reg[0]) acc_next = acc_reg + d_reg;
            g_next = g_reg >> 1;
            d_next = d_reg <<< 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CycBits'(GainBits - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        g_reg <= g_next;
        d_reg <= d_next;
    end

    // floor shift is arithmetic shift right
    assign shf = acc_reg >>> FracBits;
    assign smax = ProdBits'({1'b0, {(SampleBits-1){1'b1}}});
    assign smin = -smax - 1;
    assign done = done_reg;
    always_comb begin
        if (shf > smax) result = smax[SampleBits-1:0];
        else if (shf < smin) result = smin[SampleBits-1:0];
        else result = shf[SampleBits-1:0];
    end
endmodule

[rtl/core/mmcc_div.sv]
// restoring divider, one quotient bit per cycle, for the axis gains
// depends on mmcc_pkg
module mmcc_div
    import mmcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  div_req_t             req,
    output logic                 done,
    output logic [GainBits-1:0]  gain
);
    localparam int NumBits = SampleBits + 1 + FracBits;
    localparam int QBits = NumBits;
    logic [NumBits-1:0] num_reg, num_next;
    logic [SampleBits+1:0] rem_reg, rem_next;
    logic [SampleBits:0] den_reg, den_next;
    logic [QBits-1:0] q_reg, q_next;
    logic [CycBits:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic busy_prev_reg;
    logic [SampleBits+1:0] trial;

    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[SampleBits:0], num_reg[NumBits-1]};
        if (req.start) begin
            num_next = {req.top, {FracBits{1'b0}}};
            rem_next = '0;
            den_next = req.span;
            q_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[QBits-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[QBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == (CycBits+1)'(NumBits - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    assign done = !busy_reg && busy_prev_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) busy_prev_reg <= 1'b0;
        else busy_prev_reg <= busy_reg;
    end
    always_comb begin
        if (den_reg == '0 || q_reg[QBits-1:GainBits] != '0) gain = GainSat;
        else gain = q_reg[GainBits-1:0];
    end
endmodule

[rtl/core/mag_minmax_calibrate_correct.sv]
// magnetometer min/max calibration and hard/soft iron correction, top level
// uses mmcc_pkg, mmcc_mul and mmcc_div
// channels: s_axis beat carries one sample (x, y, z in tdata, start_cal in tuser),
// m_axis beat returns corrected x, y, z in tdata and calibrating, cal_done in tuser.
// cfg channel writes apply_correction (0), cal_sample_count (1), accept_limit (2);
// a write is taken only while idle, ahead of a sample offered in the same cycle.
// one sample is handled at a time: with correction on the three axes go through
// one bit-serial multiplier in turn before the result is offered; with correction
// off the multiplier is skipped. a sample that ends a run then runs the shared
// bit-serial divider three times, once per axis, before its result; new offsets
// and gains apply from the next sample.
// reset restores offsets 232/-221/-119, gains 4792/5485/4096 (q4.12),
// correction on, count 1000, limit 500 and no run active.
// the result waits in an output register while m_axis_tready is low; a new
// sample is taken only after the result has been delivered.
module mag_minmax_calibrate_correct
    import mmcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mag_x, mag_y, mag_z
    input  logic        s_axis_tuser,   // start_cal
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // corr_x, corr_y, corr_z
    output logic [1:0]  m_axis_tuser,   // calibrating, cal_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic apply_reg;
    logic [CountBits-1:0] count_cfg_reg;
    logic [LimitBits-1:0] limit_reg;
    logic signed [SampleBits-1:0] smp_reg [3];
    logic signed [SampleBits-1:0] res_reg [3];
    logic signed [SampleBits-1:0] max_reg [3];
    logic signed [SampleBits-1:0] min_reg [3];
    logic signed [SampleBits-1:0] off_reg [3];
    logic signed [SampleBits-1:0] mid_reg [3];
    logic [GainBits-1:0] gain_reg [3];
    logic [SampleBits:0] span_reg [3];
    logic [SampleBits:0] top_reg;
    logic [CountBits-1:0] acc_cnt_reg;
    logic active_reg, done_reg, fin_reg;
    logic [1:0] axis_reg;
    logic mul_busy_reg, div_busy_reg;
    logic mul_start, mul_done;
    logic signed [SampleBits-1:0] mul_res;
    logic signed [SampleBits:0] diff;
    div_req_t dreq;
    logic div_done;
    logic [GainBits-1:0] div_gain;
    logic s_acc, m_acc;
    logic signed [SampleBits-1:0] in_s [3];
    logic act_now, ok, finish;
    logic signed [SampleBits-1:0] nmax [3], nmin [3];
    logic [SampleBits:0] nspan [3];
    logic signed [SampleBits:0] sum [3];
    logic [SampleBits-1:0] absv [3];

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {res_reg[2], res_reg[1], res_reg[0]};
    assign m_axis_tuser = {done_reg, active_reg};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_s[i] = s_axis_tdata[i*SampleBits +: SampleBits];
            absv[i] = in_s[i][SampleBits-1] ? -in_s[i] : in_s[i];
        end
    end

    always_comb begin
        act_now = s_axis_tuser || active_reg;
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if ({1'b0, absv[i]} >= {2'b0, limit_reg}) ok = 1'b0;
            if (in_s[i][SampleBits-1] && absv[i] == {1'b1, {(SampleBits-1){1'b0}}})
                ok = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            nmax[i] = s_axis_tuser ? MaxInit : max_reg[i];
            nmin[i] = s_axis_tuser ? MinInit : min_reg[i];
            if (in_s[i] > nmax[i]) nmax[i] = in_s[i];
            if (in_s[i] < nmin[i]) nmin[i] = in_s[i];
            nspan[i] = (SampleBits+1)'({nmax[i][SampleBits-1], nmax[i]}
                       - {nmin[i][SampleBits-1], nmin[i]});
            sum[i] = {nmax[i][SampleBits-1], nmax[i]} + {nmin[i][SampleBits-1], nmin[i]};
        end
        finish = act_now && ok &&
                 ((s_axis_tuser ? '0 : acc_cnt_reg) >= count_cfg_reg);
    end

    assign diff = {smp_reg[axis_reg][SampleBits-1], smp_reg[axis_reg]}
                - {off_reg[axis_reg][SampleBits-1], off_reg[axis_reg]};
    assign mul_start = (state_reg == ST_MUL) && apply_reg && !mul_busy_reg;

    mmcc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .diff(diff),
        .gain(gain_reg[axis_reg]), .done(mul_done), .result(mul_res)
    );

    assign dreq = {(state_reg == ST_DIV) && !div_busy_reg, top_reg, span_reg[axis_reg]};

    mmcc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(div_done),
                    .gain(div_gain));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_MUL;
            ST_MUL:  if (!apply_reg || (mul_done && axis_reg == 2'd2))
                         state_next = fin_reg ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done && axis_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:  if (m_acc) state_next = ST_IDLE;
            ST_WAIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            apply_reg <= 1'b1;
            count_cfg_reg <= 16'd1000;
            limit_reg <= 15'd500;
            active_reg <= 1'b0;
            done_reg <= 1'b0;
            fin_reg <= 1'b0;
            acc_cnt_reg <= '0;
            axis_reg <= '0;
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                max_reg[i] <= MaxInit;
                min_reg[i] <= MinInit;
            end
            off_reg[0] <= Off0; off_reg[1] <= Off1; off_reg[2] <= Off2;
            gain_reg[0] <= Gain0; gain_reg[1] <= Gain1; gain_reg[2] <= Gain2;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    RegApply: apply_reg <= cfg_data[0];
                    RegCount: count_cfg_reg <= cfg_data;
                    RegLimit: limit_reg <= cfg_data[LimitBits-1:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                axis_reg <= '0;
                fin_reg <= finish;
                done_reg <= finish;
                active_reg <= act_now && !finish;
                if (act_now && ok) begin
                    acc_cnt_reg <= finish ? '0
                        : (s_axis_tuser ? CountBits'(1) : acc_cnt_reg + 1'b1);
                    for (int i = 0; i < 3; i++) begin
                        max_reg[i] <= nmax[i];
                        min_reg[i] <= nmin[i];
                    end
                end else if (s_axis_tuser) begin
                    acc_cnt_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        max_reg[i] <= MaxInit;
                        min_reg[i] <= MinInit;
                    end
                end
                if (finish) begin
                    for (int i = 0; i < 3; i++) begin
                        span_reg[i] <= nspan[i];
                        // midpoint truncated toward zero
                        mid_reg[i] <= SampleBits'((sum[i] + (sum[i][SampleBits] ?
                                      (SampleBits+1)'(1) : '0)) >>> 1);
                    end
                    top_reg <= (nspan[0] >= nspan[1] && nspan[0] >= nspan[2]) ? nspan[0]
                             : (nspan[1] >= nspan[2]) ? nspan[1] : nspan[2];
                end
            end
            if (state_reg == ST_MUL) begin
                if (!apply_reg) begin
                    axis_reg <= '0;
                end else begin
                    mul_busy_reg <= mul_start ? 1'b1 : (mul_done ? 1'b0 : mul_busy_reg);
                    if (mul_done) axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 1'b1;
                end
            end
            if (state_reg == ST_DIV) begin
                div_busy_reg <= dreq.start ? 1'b1 : (div_done ? 1'b0 : div_busy_reg);
                if (div_done) begin
                    gain_reg[axis_reg] <= div_gain;
                    off_reg[axis_reg] <= mid_reg[axis_reg];
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < 3; i++) begin
                smp_reg[i] <= in_s[i];
                res_reg[i] <= in_s[i];
            end
        end else if (state_reg == ST_MUL && apply_reg && mul_done) begin
            res_reg[axis_reg] <= mul_res;
        end
    end

    a_done_not_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("cal_done with run still active");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    a_cnt_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && finish) |=> acc_cnt_reg == '0)
        else $error("count not cleared at end of run");
endmodule
